// ----- hdl/rtmt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtmt_pkg
// Shared types and constants of the rich text markup tokenizer.
// ----------------------------------------------------------------------------
package rtmt_pkg;

  // Strings longer than this many bytes are rejected.
  localparam int MAX_STRING_LEN = 65535;
  localparam int PosW = 16;

  localparam logic [7:0] ChLt      = 8'h3C;  // '<'
  localparam logic [7:0] ChSlash   = 8'h2F;  // '/'
  localparam logic [7:0] ChGt      = 8'h3E;  // '>'
  localparam logic [7:0] ChEq      = 8'h3D;  // '='
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChLowA    = 8'h61;  // 'a'
  localparam logic [7:0] ChLowZ    = 8'h7A;  // 'z'

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_NEWLINE = 3'd1,
    KIND_SPACE   = 3'd2,
    KIND_WORD    = 3'd3,
    KIND_START   = 3'd4,
    KIND_ENDTAG  = 3'd5,
    KIND_ERROR   = 3'd6
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_SPACE   = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_NAME    = 3'd5,
    MODE_VALUE   = 3'd6,
    MODE_DEAD    = 3'd7
  } lex_mode_t;

  typedef struct packed {
    token_kind_t       kind;
    logic [PosW-1:0]   text_start;
    logic [PosW-1:0]   text_length;
    logic [PosW-1:0]   value_index;
    logic [PosW-1:0]   value_length;
  } token_t;

  localparam token_t TokenZero = '{kind: KIND_END, default: '0};

  // Up to three tokens caused by one byte, in order, plus how many are valid.
  typedef struct packed {
    logic [1:0]        count;
    token_t [2:0]      tokens;
  } bundle_t;

  localparam int TokenDataW = 3 + 4 * PosW;
  localparam int OutDataW   = ((TokenDataW + 7) / 8) * 8;

endpackage

// ----- hdl/rich_text_markup_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// rich_text_markup_tokenizer_core
// Streaming tokenizer for a small rich text markup, one byte per transaction.
// ----------------------------------------------------------------------------
// Bytes of a string arrive on the slave stream, with tlast on the final byte.
// Each byte is lexed in the cycle it is accepted: the lexer state registers
// are updated and the zero to three tokens the byte causes are captured in a
// result register, from which they leave on the master stream one per cycle
// while m_tready is high, from the cycle after the byte is accepted, with
// tlast on the last token of that byte. A byte causing at most one token is
// taken every cycle while the output keeps up; one causing two or three
// tokens holds the output until all have left, and the next byte is taken
// only in the cycle its last token leaves, as the single output port sets the
// pace. Token kinds are end, newline, space run, word, start tag (name plus
// optional value after '='), end tag and error; text is reported as start
// index and length within the string. After an error the rest of the string
// is dropped without output, and the final byte of every string returns the
// lexer to its initial state. A byte at index MAX_STRING_LEN or beyond, that
// is, a string longer than MAX_STRING_LEN bytes, produces an error token.
module rich_text_markup_tokenizer_core import rtmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] char_byte
  input  logic                s_tlast,   // final_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  // [2:0] token_kind, [18:3] text_start, [34:19] text_length,
  // [50:35] value_index, [66:51] value_length, upper bits zero.
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast    // last_of_run
);

  logic    accept;
  logic    in_ready;
  bundle_t bundle;
  token_t  out_token;

  assign s_tready = in_ready;
  assign accept   = s_tvalid && in_ready;

  rtmt_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_byte  (s_tdata),
    .final_byte (s_tlast),
    .bundle     (bundle)
  );

  // Bytes that cause no token leave the result register untouched.
  rtmt_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (bundle.count != 2'd0)),
    .bundle    (bundle),
    .in_ready  (in_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_token (out_token),
    .out_last  (m_tlast)
  );

  assign m_tdata = OutDataW'({out_token.value_length, out_token.value_index,
                              out_token.text_length, out_token.text_start,
                              out_token.kind});

endmodule

// ----- hdl/rtmt_lexer.sv -----
// ----------------------------------------------------------------------------
// rtmt_lexer
// Lexer state registers and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
module rtmt_lexer import rtmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       final_byte,
  output bundle_t    bundle
);

  localparam logic [PosW:0] MaxPos = (PosW + 1)'(MAX_STRING_LEN);

  lex_mode_t       lex_mode, lex_mode_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [PosW-1:0] token_begin, token_begin_next;
  logic [PosW-1:0] name_length, name_length_next;
  logic [PosW-1:0] value_begin, value_begin_next;

  logic            is_blank;
  logic            is_lower;
  logic [PosW-1:0] pos_inc;

  // Effect of a byte that opens a new token.
  lex_mode_t       st_mode;
  logic [PosW-1:0] st_begin;
  logic            st_newline;

  logic [1:0]      n;

  assign is_blank = (char_byte == ChSpace) || (char_byte == ChTab);
  assign is_lower = (char_byte >= ChLowA) && (char_byte <= ChLowZ);
  assign pos_inc  = byte_position + PosW'(1);

  always_comb begin
    st_mode    = MODE_WORD;
    st_begin   = byte_position;
    st_newline = 1'b0;
    if (char_byte == ChNewline) begin
      st_mode    = MODE_BETWEEN;
      st_begin   = token_begin;
      st_newline = 1'b1;
    end else if (is_blank) begin
      st_mode  = MODE_SPACE;
      st_begin = token_begin;
    end else if (char_byte == ChLt) begin
      st_mode  = MODE_OPEN;
      st_begin = pos_inc;
    end
  end

  always_comb begin
    lex_mode_next      = lex_mode;
    byte_position_next = byte_position;
    token_begin_next   = token_begin;
    name_length_next   = name_length;
    value_begin_next   = value_begin;
    n                  = 2'd0;
    bundle.tokens      = {3{TokenZero}};

    if (lex_mode != MODE_DEAD) begin
      if ({1'b0, byte_position} >= MaxPos) begin
        bundle.tokens[n].kind = KIND_ERROR;
        n = n + 2'd1;
        lex_mode_next = MODE_DEAD;
      end else begin
        unique case (lex_mode)
          MODE_SPACE, MODE_WORD, MODE_BETWEEN: begin
            if (lex_mode == MODE_BETWEEN || (lex_mode == MODE_SPACE && !is_blank) ||
                (lex_mode == MODE_WORD && (is_blank || char_byte == ChNewline ||
                                           char_byte == ChLt))) begin
              if (lex_mode == MODE_SPACE) begin
                bundle.tokens[n].kind = KIND_SPACE;
                n = n + 2'd1;
              end else if (lex_mode == MODE_WORD) begin
                bundle.tokens[n].kind        = KIND_WORD;
                bundle.tokens[n].text_start  = token_begin;
                bundle.tokens[n].text_length = byte_position - token_begin;
                n = n + 2'd1;
              end
              if (st_newline) begin
                bundle.tokens[n].kind = KIND_NEWLINE;
                n = n + 2'd1;
              end
              lex_mode_next    = st_mode;
              token_begin_next = st_begin;
            end
          end
          MODE_OPEN, MODE_NAME: begin
            if (lex_mode == MODE_OPEN && char_byte == ChSlash) begin
              lex_mode_next = MODE_SLASH;
            end else if (is_lower) begin
              lex_mode_next = MODE_NAME;
            end else if (char_byte == ChEq) begin
              name_length_next = byte_position - token_begin;
              value_begin_next = pos_inc;
              lex_mode_next    = MODE_VALUE;
            end else if (char_byte == ChGt) begin
              bundle.tokens[n].kind        = KIND_START;
              bundle.tokens[n].text_start  = token_begin;
              bundle.tokens[n].text_length = byte_position - token_begin;
              n = n + 2'd1;
              lex_mode_next = MODE_BETWEEN;
            end else begin
              bundle.tokens[n].kind = KIND_ERROR;
              n = n + 2'd1;
              lex_mode_next = MODE_DEAD;
            end
          end
          MODE_SLASH: begin
            if (char_byte == ChGt) begin
              bundle.tokens[n].kind = KIND_ENDTAG;
              lex_mode_next = MODE_BETWEEN;
            end else begin
              bundle.tokens[n].kind = KIND_ERROR;
              lex_mode_next = MODE_DEAD;
            end
            n = n + 2'd1;
          end
          MODE_VALUE: begin
            if (char_byte == ChGt) begin
              bundle.tokens[n].kind         = KIND_START;
              bundle.tokens[n].text_start   = token_begin;
              bundle.tokens[n].text_length  = name_length;
              bundle.tokens[n].value_index  = value_begin;
              bundle.tokens[n].value_length = byte_position - value_begin;
              n = n + 2'd1;
              lex_mode_next = MODE_BETWEEN;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (final_byte) begin
      unique case (lex_mode_next)
        MODE_SPACE: begin
          bundle.tokens[n].kind = KIND_SPACE;
          n = n + 2'd1;
          bundle.tokens[n].kind = KIND_END;
          n = n + 2'd1;
        end
        MODE_WORD: begin
          bundle.tokens[n].kind        = KIND_WORD;
          bundle.tokens[n].text_start  = token_begin_next;
          bundle.tokens[n].text_length = pos_inc - token_begin_next;
          n = n + 2'd1;
          bundle.tokens[n].kind = KIND_END;
          n = n + 2'd1;
        end
        MODE_OPEN, MODE_SLASH, MODE_NAME, MODE_VALUE: begin
          bundle.tokens[n].kind = KIND_ERROR;
          n = n + 2'd1;
        end
        MODE_DEAD: begin
        end
        default: begin
          bundle.tokens[n].kind = KIND_END;
          n = n + 2'd1;
        end
      endcase
      lex_mode_next      = MODE_BETWEEN;
      byte_position_next = '0;
      token_begin_next   = '0;
      name_length_next   = '0;
      value_begin_next   = '0;
    end else if (lex_mode_next != MODE_DEAD) begin
      byte_position_next = pos_inc;
    end

    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= MODE_BETWEEN;
      byte_position <= '0;
      token_begin   <= '0;
      name_length   <= '0;
      value_begin   <= '0;
    end else if (accept) begin
      lex_mode      <= lex_mode_next;
      byte_position <= byte_position_next;
      token_begin   <= token_begin_next;
      name_length   <= name_length_next;
      value_begin   <= value_begin_next;
    end
  end

endmodule

// ----- hdl/rtmt_unpack.sv -----
// ----------------------------------------------------------------------------
// rtmt_unpack
// Result register of one byte's tokens, given out one per cycle on out_ready.
// ----------------------------------------------------------------------------
module rtmt_unpack import rtmt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  bundle_t bundle,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output token_t  out_token,
  output logic    out_last
);

  token_t [2:0] slots;
  logic [1:0]   count;
  logic [1:0]   ptr;
  logic         take;
  logic         done;

  assign out_valid = (count != 2'd0);
  assign out_token = slots[ptr];
  assign out_last  = (ptr == count - 2'd1);
  assign take      = out_valid && out_ready;
  assign done      = take && out_last;
  assign in_ready  = !out_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else if (load) begin
      count <= bundle.count;
      ptr   <= '0;
    end else if (done) begin
      count <= '0;
      ptr   <= '0;
    end else if (take) begin
      ptr <= ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle.tokens;
    end
  end

endmodule
